FILE: rtl/core/dsl_pkg.sv
// Package for the DWT subband layout block: sequencer states, orientation
// codes and the fixed field widths of the descriptor. No dependencies.
`default_nettype none

package dsl_pkg;

  localparam int LVL_W = 4;   // level field, also the shift amount
  localparam int IDX_W = 6;   // internal band index, up to 1+3*15 bands
  localparam int OFF_W = 32;  // band offset, kept modulo 2^32
  localparam int OUT_W = 16;  // band width and height ports

  localparam logic [1:0] ORI_LL = 2'd0;
  localparam logic [1:0] ORI_HL = 2'd1;
  localparam logic [1:0] ORI_LH = 2'd2;
  localparam logic [1:0] ORI_HH = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LL_X,
    ST_LL_Y,
    ST_LVL_X,
    ST_LVL_Y,
    ST_MUL,
    ST_ACC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic mul_en;
    logic acc_en;
    logic acc_clr;
  } mac_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/core/dwt_subband_layout_top.sv
// Top level of the DWT subband layout generator: sequencer, shared shift
// unit and shared multiply-accumulate. Uses dsl_pkg, dsl_ceil_shift, dsl_mac_unit.
//
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready  | image_width, image_height, level_count
//  out_    | output    | out_valid/out_ready  | band_index .. last_band, 1+3*levels items
//
// With out_ready held high, a request passes through the idle state that takes it,
// two shift steps and an emit for the LL band, then per level two shift steps and
// multiply, accumulate and emit steps for each band, in that order.
// in_ready is high only while idle; a request is taken, then all its items leave.
// A low out_ready holds the current item on the ports and stalls the sequencer.
// rst_n is synchronous and returns the block to idle.
`default_nettype none

module dwt_subband_layout_top
  import dsl_pkg::*;
#(
  parameter int MAX_LEVELS = 8,
  parameter int DIM_BITS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_image_width,
  input  wire logic [15:0] in_image_height,
  input  wire logic [3:0]  in_level_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [4:0]       out_band_index,
  output logic [3:0]       out_band_level,
  output logic [1:0]       out_orientation,
  output logic [31:0]      out_band_offset,
  output logic [15:0]      out_band_width,
  output logic [15:0]      out_band_height,
  output logic             out_last_band
);

  state_t state_r, state_nxt;

  logic [DIM_BITS-1:0] dimx_r, dimx_nxt;
  logic [DIM_BITS-1:0] dimy_r, dimy_nxt;
  logic [DIM_BITS-1:0] sx_r, sx_nxt;
  logic [DIM_BITS-1:0] sy_r, sy_nxt;
  logic [LVL_W-1:0]    levels_r, levels_nxt;
  logic [LVL_W-1:0]    lvl_r, lvl_nxt;
  logic [IDX_W-1:0]    idx_r, idx_nxt;
  logic [IDX_W-1:0]    last_idx_r, last_idx_nxt;
  logic [1:0]          orient_r, orient_nxt;

  logic [LVL_W-1:0]    lv_sat;
  logic [DIM_BITS-1:0] shf_value, shf_result;
  logic [LVL_W-1:0]    shf_amount;
  logic [DIM_BITS-1:0] hx, lx, hy, ly;
  logic [DIM_BITS-1:0] mul_a, mul_b;
  logic [DIM_BITS-1:0] band_w, band_h;
  logic [OFF_W-1:0]    acc;
  mac_ctrl_t           mac_ctrl;

  assign lv_sat = (32'(in_level_count) > MAX_LEVELS) ? LVL_W'(MAX_LEVELS) : in_level_count;

  // split of the current level's input size
  assign hx = sx_r >> 1;
  assign lx = sx_r - hx;
  assign hy = sy_r >> 1;
  assign ly = sy_r - hy;

  assign shf_value  = (state_r == ST_LL_X || state_r == ST_LVL_X) ? dimx_r : dimy_r;
  assign shf_amount = (state_r == ST_LL_X || state_r == ST_LL_Y) ? levels_r
                                                                 : lvl_r - LVL_W'(1);

  dsl_ceil_shift #(
    .W(DIM_BITS)
  ) u_shift (
    .value (shf_value),
    .amount(shf_amount),
    .result(shf_result)
  );

  always_comb begin
    case (orient_r)
      ORI_HL: begin
        mul_a = lx; mul_b = ly; band_w = hx; band_h = ly;
      end
      ORI_LH: begin
        mul_a = hx; mul_b = ly; band_w = lx; band_h = hy;
      end
      ORI_HH: begin
        mul_a = lx; mul_b = hy; band_w = hx; band_h = hy;
      end
      default: begin
        mul_a = lx; mul_b = ly; band_w = sx_r; band_h = sy_r;
      end
    endcase
  end

  dsl_mac_unit #(
    .OPW(DIM_BITS)
  ) u_mac (
    .clk (clk),
    .ctrl(mac_ctrl),
    .op_a(mul_a),
    .op_b(mul_b),
    .acc (acc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
    dimx_r     <= dimx_nxt;
    dimy_r     <= dimy_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    levels_r   <= levels_nxt;
    lvl_r      <= lvl_nxt;
    last_idx_r <= last_idx_nxt;
    orient_r   <= orient_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    dimx_nxt     = dimx_r;
    dimy_nxt     = dimy_r;
    sx_nxt       = sx_r;
    sy_nxt       = sy_r;
    levels_nxt   = levels_r;
    lvl_nxt      = lvl_r;
    idx_nxt      = idx_r;
    last_idx_nxt = last_idx_r;
    orient_nxt   = orient_r;
    mac_ctrl     = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          dimx_nxt     = DIM_BITS'(in_image_width);
          dimy_nxt     = DIM_BITS'(in_image_height);
          levels_nxt   = lv_sat;
          idx_nxt      = '0;
          orient_nxt   = ORI_LL;
          last_idx_nxt = IDX_W'(lv_sat) + IDX_W'({lv_sat, 1'b0});
          state_nxt    = ST_LL_X;
        end
      end
      ST_LL_X: begin
        sx_nxt           = shf_result;
        mac_ctrl.acc_clr = 1'b1;
        state_nxt        = ST_LL_Y;
      end
      ST_LL_Y: begin
        sy_nxt    = shf_result;
        state_nxt = ST_EMIT;
      end
      ST_LVL_X: begin
        sx_nxt           = shf_result;
        mac_ctrl.acc_clr = 1'b1;
        state_nxt        = ST_LVL_Y;
      end
      ST_LVL_Y: begin
        sy_nxt     = shf_result;
        orient_nxt = ORI_HL;
        state_nxt  = ST_MUL;
      end
      ST_MUL: begin
        mac_ctrl.mul_en = 1'b1;
        state_nxt       = ST_ACC;
      end
      ST_ACC: begin
        mac_ctrl.acc_en = 1'b1;
        state_nxt       = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready) begin
          idx_nxt = idx_r + IDX_W'(1);
          if (orient_r == ORI_LL) begin
            lvl_nxt   = levels_r;
            state_nxt = (levels_r == '0) ? ST_IDLE : ST_LVL_X;
          end else if (orient_r != ORI_HH) begin
            orient_nxt = orient_r + 2'd1;
            state_nxt  = ST_MUL;
          end else begin
            // level done: step one level toward the full-size image
            lvl_nxt   = lvl_r - LVL_W'(1);
            state_nxt = (lvl_r == LVL_W'(1)) ? ST_IDLE : ST_LVL_X;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign in_ready        = (state_r == ST_IDLE);
  assign out_valid       = (state_r == ST_EMIT);
  assign out_band_index  = idx_r[4:0];
  assign out_band_level  = (orient_r == ORI_LL) ? levels_r : lvl_r;
  assign out_orientation = orient_r;
  assign out_band_offset = acc;
  assign out_band_width  = OUT_W'(band_w);
  assign out_band_height = OUT_W'(band_h);
  assign out_last_band   = (idx_r == last_idx_r);

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_band |=> in_ready)
    else $error("block not idle after last item");

  a_more_stays_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_band |=> !in_ready)
    else $error("block idle before last item");

  a_start_at_ll: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> (idx_r == '0) && (orient_r == ORI_LL))
    else $error("request does not start with the LL band");

  a_ll_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_orientation == ORI_LL) |-> (out_band_offset == '0))
    else $error("LL band with nonzero offset");

  a_detail_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_orientation != ORI_LL) |-> (out_band_level != '0))
    else $error("detail band at level zero");

endmodule

`default_nettype wire

FILE: rtl/core/dsl_ceil_shift.sv
// Shared shift unit: ceil(value / 2^amount) for one dimension.
// Uses dsl_pkg for the shift amount width.
`default_nettype none

module dsl_ceil_shift
  import dsl_pkg::*;
#(
  parameter int W = 16
) (
  input  wire logic [W-1:0]     value,
  input  wire logic [LVL_W-1:0] amount,
  output logic      [W-1:0]     result
);

  logic [W-1:0] low_mask;
  logic         round_up;

  always_comb begin
    // bits shifted out; any one set rounds the quotient up
    low_mask = ~({W{1'b1}} << amount);
    round_up = |(value & low_mask);
    result   = (value >> amount) + W'(round_up);
  end

endmodule

`default_nettype wire

FILE: rtl/core/dsl_mac_unit.sv
// Shared multiply-accumulate unit for band offsets: registered product,
// then a registered running sum modulo 2^32. Uses dsl_pkg for control.
`default_nettype none

module dsl_mac_unit
  import dsl_pkg::*;
#(
  parameter int OPW = 16
) (
  input  wire logic              clk,
  input  wire mac_ctrl_t         ctrl,
  input  wire logic [OPW-1:0]    op_a,
  input  wire logic [OPW-1:0]    op_b,
  output logic      [OFF_W-1:0]  acc
);

  logic [OFF_W-1:0] prod_r;
  logic [OFF_W-1:0] acc_r;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= OFF_W'(op_a) * OFF_W'(op_b);
    end
    if (ctrl.acc_clr) begin
      acc_r <= '0;
    end else if (ctrl.acc_en) begin
      acc_r <= acc_r + prod_r;
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire
